// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL. Define ASSERT_OFF to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: rtl/rpi_pkg.sv
package rpi_pkg;

  localparam int WORD_W  = 32;
  localparam int FRAC_W  = 16;
  localparam int CFG_IDX_W = 3;
  // n.(c - o) is a sum of three 32 x 33 bit products, n.d of three 32 x 32.
  localparam int NUM_W   = 67;
  localparam int DEN_W   = 66;
  localparam int SN_W    = NUM_W + FRAC_W;
  localparam int AD_W    = DEN_W;
  localparam int Q_W     = 31;
  localparam int CMP_W   = AD_W + Q_W;

  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 3'd5;

  localparam logic [WORD_W-1:0] NORMAL_Z_RESET = 32'h0001_0000;

  typedef struct packed {
    logic signed [WORD_W-1:0] origin_x;
    logic signed [WORD_W-1:0] origin_y;
    logic signed [WORD_W-1:0] origin_z;
    logic signed [WORD_W-1:0] dir_x;
    logic signed [WORD_W-1:0] dir_y;
    logic signed [WORD_W-1:0] dir_z;
    logic                     backwards;
  } in_word_t;

  typedef struct packed {
    logic                     hit;
    logic signed [WORD_W-1:0] point_x;
    logic signed [WORD_W-1:0] point_y;
    logic signed [WORD_W-1:0] point_z;
  } out_word_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] normal_x;
    logic signed [WORD_W-1:0] normal_y;
    logic signed [WORD_W-1:0] normal_z;
    logic signed [WORD_W-1:0] center_x;
    logic signed [WORD_W-1:0] center_y;
    logic signed [WORD_W-1:0] center_z;
  } plane_t;

  // Quotient side information that travels alongside the divider.
  typedef struct packed {
    logic neg;
    logic zero;
    logic sat;
  } div_flags_t;

endpackage

// File: rtl/rpi_dot.sv
module rpi_dot (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_valid,
  input  rpi_pkg::in_word_t               in_word,
  input  rpi_pkg::plane_t                 plane,
  output logic                            out_valid,
  output rpi_pkg::in_word_t               out_word,
  output logic [rpi_pkg::SN_W-1:0]        sn,
  output logic [rpi_pkg::AD_W-1:0]        ad,
  output logic                            neg,
  output logic                            zero
);

  logic signed [rpi_pkg::WORD_W:0]     dx, dy, dz;
  logic signed [rpi_pkg::WORD_W*2:0]   pn_x_nxt, pn_y_nxt, pn_z_nxt;
  logic signed [rpi_pkg::WORD_W*2:0]   pn_x_r, pn_y_r, pn_z_r;
  logic signed [rpi_pkg::WORD_W*2-1:0] pd_x_nxt, pd_y_nxt, pd_z_nxt;
  logic signed [rpi_pkg::WORD_W*2-1:0] pd_x_r, pd_y_r, pd_z_r;
  logic signed [rpi_pkg::NUM_W-1:0]    num_nxt, num_r;
  logic signed [rpi_pkg::DEN_W-1:0]    den_nxt, den_r;
  logic [rpi_pkg::NUM_W-1:0]           an;
  logic [rpi_pkg::AD_W-1:0]            ad_nxt, ad_r;
  logic [rpi_pkg::SN_W-1:0]            sn_r;
  logic                                neg_r, zero_r;
  logic                                va_r, vb_r, vc_r;
  rpi_pkg::in_word_t                   wa_r, wb_r, wc_r;

  // Stage A: the six products.
  assign dx = $signed({plane.center_x[rpi_pkg::WORD_W-1], plane.center_x})
            - $signed({in_word.origin_x[rpi_pkg::WORD_W-1], in_word.origin_x});
  assign dy = $signed({plane.center_y[rpi_pkg::WORD_W-1], plane.center_y})
            - $signed({in_word.origin_y[rpi_pkg::WORD_W-1], in_word.origin_y});
  assign dz = $signed({plane.center_z[rpi_pkg::WORD_W-1], plane.center_z})
            - $signed({in_word.origin_z[rpi_pkg::WORD_W-1], in_word.origin_z});

  assign pn_x_nxt = $signed(plane.normal_x) * dx;
  assign pn_y_nxt = $signed(plane.normal_y) * dy;
  assign pn_z_nxt = $signed(plane.normal_z) * dz;
  assign pd_x_nxt = $signed(plane.normal_x) * $signed(in_word.dir_x);
  assign pd_y_nxt = $signed(plane.normal_y) * $signed(in_word.dir_y);
  assign pd_z_nxt = $signed(plane.normal_z) * $signed(in_word.dir_z);

  // Stage B: the two dot-product sums.
  assign num_nxt = rpi_pkg::NUM_W'(pn_x_r) + rpi_pkg::NUM_W'(pn_y_r)
                 + rpi_pkg::NUM_W'(pn_z_r);
  assign den_nxt = rpi_pkg::DEN_W'(pd_x_r) + rpi_pkg::DEN_W'(pd_y_r)
                 + rpi_pkg::DEN_W'(pd_z_r);

  // Stage C: magnitudes and the pre-scaled dividend.
  assign an     = num_r[rpi_pkg::NUM_W-1] ? rpi_pkg::NUM_W'(-num_r) : rpi_pkg::NUM_W'(num_r);
  assign ad_nxt = den_r[rpi_pkg::DEN_W-1] ? rpi_pkg::AD_W'(-den_r) : rpi_pkg::AD_W'(den_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pn_x_r <= pn_x_nxt;
      pn_y_r <= pn_y_nxt;
      pn_z_r <= pn_z_nxt;
      pd_x_r <= pd_x_nxt;
      pd_y_r <= pd_y_nxt;
      pd_z_r <= pd_z_nxt;
      wa_r   <= in_word;
      num_r  <= num_nxt;
      den_r  <= den_nxt;
      wb_r   <= wa_r;
      sn_r   <= {an, {rpi_pkg::FRAC_W{1'b0}}};
      ad_r   <= ad_nxt;
      neg_r  <= num_r[rpi_pkg::NUM_W-1] ^ den_r[rpi_pkg::DEN_W-1];
      zero_r <= (den_r == '0);
      wc_r   <= wb_r;
    end
  end

  assign out_valid = vc_r;
  assign out_word  = wc_r;
  assign sn        = sn_r;
  assign ad        = ad_r;
  assign neg       = neg_r;
  assign zero      = zero_r;

endmodule

// File: rtl/rpi_div.sv
`include "assert_macros.svh"

module rpi_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  rpi_pkg::in_word_t           in_word,
  input  logic [rpi_pkg::SN_W-1:0]    sn,
  input  logic [rpi_pkg::AD_W-1:0]    ad,
  input  logic                        neg,
  input  logic                        zero,
  output logic                        out_valid,
  output rpi_pkg::in_word_t           out_word,
  output logic [rpi_pkg::Q_W-1:0]     quot,
  output rpi_pkg::div_flags_t         flags
);

  localparam int NS = rpi_pkg::Q_W + 1;

  logic                        v_r   [0:NS-1];
  rpi_pkg::in_word_t           w_r   [0:NS-1];
  logic [rpi_pkg::SN_W-1:0]    rem_r [0:NS-1];
  logic [rpi_pkg::AD_W-1:0]    ad_r  [0:NS-1];
  logic [rpi_pkg::Q_W-1:0]     q_r   [0:NS-1];
  rpi_pkg::div_flags_t         f_r   [0:NS-1];
  rpi_pkg::div_flags_t         f_nxt;

  // First stage: a quotient of 2^31 or more saturates either way.
  always_comb begin
    f_nxt.neg  = neg;
    f_nxt.zero = zero;
    f_nxt.sat  = rpi_pkg::CMP_W'(sn) >= {ad, {rpi_pkg::Q_W{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_r[0]   <= in_word;
      rem_r[0] <= sn;
      ad_r[0]  <= ad;
      q_r[0]   <= '0;
      f_r[0]   <= f_nxt;
    end
  end

  // One restoring step per stage, most significant quotient bit first.
  for (genvar k = 0; k < rpi_pkg::Q_W; k++) begin : g_step
    localparam int SH = rpi_pkg::Q_W - 1 - k;
    logic [rpi_pkg::CMP_W-1:0] dsh;
    logic                      ge;
    logic [rpi_pkg::SN_W-1:0]  rem_nxt;
    logic [rpi_pkg::Q_W-1:0]   q_nxt;

    always_comb begin
      dsh     = rpi_pkg::CMP_W'(ad_r[k]) << SH;
      ge      = rpi_pkg::CMP_W'(rem_r[k]) >= dsh;
      rem_nxt = ge ? rem_r[k] - dsh[rpi_pkg::SN_W-1:0] : rem_r[k];
      q_nxt   = q_r[k];
      q_nxt[SH] = ge;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        w_r[k+1]   <= w_r[k];
        rem_r[k+1] <= rem_nxt;
        ad_r[k+1]  <= ad_r[k];
        q_r[k+1]   <= q_nxt;
        f_r[k+1]   <= f_r[k];
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_word  = w_r[NS-1];
  assign quot      = q_r[NS-1];
  assign flags     = f_r[NS-1];

  // A finished division leaves a remainder below the divisor.
  `ASSERT_IMPLY(a_rem_below_div, v_r[NS-1] && !f_r[NS-1].zero && !f_r[NS-1].sat,
                rpi_pkg::CMP_W'(rem_r[NS-1]) < rpi_pkg::CMP_W'(ad_r[NS-1]))

endmodule

// File: rtl/rpi_point.sv
`include "assert_macros.svh"

module rpi_point (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  rpi_pkg::in_word_t           in_word,
  input  logic [rpi_pkg::Q_W-1:0]     quot,
  input  rpi_pkg::div_flags_t         flags,
  output logic                        out_valid,
  output rpi_pkg::out_word_t          out_word
);

  localparam int W  = rpi_pkg::WORD_W;
  localparam int PW = 2 * rpi_pkg::WORD_W;
  localparam int SW = PW - rpi_pkg::FRAC_W;

  logic [W-1:0]          qm;
  logic signed [W-1:0]   t_nxt, t_r;
  logic                  hit_nxt, hit_r, hit_p_r;
  logic                  vt_r, vp_r, vo_r;
  rpi_pkg::in_word_t     wt_r, wp_r;
  logic signed [PW-1:0]  p_x_r, p_y_r, p_z_r;
  rpi_pkg::out_word_t    o_nxt, o_r;

  function automatic logic signed [W-1:0] coord(input logic signed [W-1:0] o,
                                                input logic signed [PW-1:0] p);
    logic signed [PW-1:0] pr;
    logic signed [SW:0]   sum;
    // Biasing a negative product before the shift truncates toward zero.
    pr  = p + PW'({rpi_pkg::FRAC_W{p[PW-1]}});
    sum = (SW+1)'(o) + (SW+1)'($signed(pr[PW-1:rpi_pkg::FRAC_W]));
    if (sum > (SW+1)'(32'sh7FFF_FFFF)) begin
      return 32'sh7FFF_FFFF;
    end else if (sum < -(SW+1)'(33'sh0_8000_0000)) begin
      return 32'sh8000_0000;
    end else begin
      return sum[W-1:0];
    end
  endfunction

  always_comb begin
    qm    = flags.sat ? 32'h8000_0000 : {1'b0, quot};
    t_nxt = flags.neg ? -$signed(qm) : (flags.sat ? 32'sh7FFF_FFFF : $signed(qm));
    hit_nxt = !flags.zero
            && (in_word.backwards ? t_nxt[W-1] : (!t_nxt[W-1] && (t_nxt != '0)));
  end

  always_comb begin
    o_nxt.hit     = hit_p_r;
    o_nxt.point_x = hit_p_r ? coord(wp_r.origin_x, p_x_r) : '0;
    o_nxt.point_y = hit_p_r ? coord(wp_r.origin_y, p_y_r) : '0;
    o_nxt.point_z = hit_p_r ? coord(wp_r.origin_z, p_z_r) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vt_r <= 1'b0;
      vp_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (en) begin
      vt_r <= in_valid;
      vp_r <= vt_r;
      vo_r <= vp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r     <= t_nxt;
      hit_r   <= hit_nxt;
      wt_r    <= in_word;
      p_x_r   <= $signed(wt_r.dir_x) * t_r;
      p_y_r   <= $signed(wt_r.dir_y) * t_r;
      p_z_r   <= $signed(wt_r.dir_z) * t_r;
      hit_p_r <= hit_r;
      wp_r    <= wt_r;
      o_r     <= o_nxt;
    end
  end

  assign out_valid = vo_r;
  assign out_word  = o_r;

  `ASSERT_IMPLY(a_miss_is_zero, vo_r && !o_r.hit,
                o_r.point_x == '0 && o_r.point_y == '0 && o_r.point_z == '0)
  `ASSERT_IMPLY(a_hit_needs_t, vt_r && hit_r, t_r != '0)
  `ASSERT_IMPLY(a_back_hit_neg, vt_r && hit_r && wt_r.backwards, t_r[W-1])

endmodule

// File: rtl/ray_plane_intersect_unit.sv
// Channel   Direction  Handshake               Word
// in_       input      in_valid / in_ready     in_data   (ray, backwards flag)
// out_      output     out_valid / out_ready   out_data  (hit, point)
// cfg_      input      cfg_wr_en               cfg_index, cfg_data (plane)
//
// One ray enters per cycle while the pipeline is not held; its result word leaves the unit
// having passed 38 register stages.
// Three stages form the dot products, 32 make up the divider (a saturation check, then
// one quotient bit per stage for 31 bits) and three form the point.
// Reset is synchronous and active low; it clears the valid bits and loads the plane
// registers with a normal of (0, 0, 1) and a centre at the origin.
// When out_valid is high and out_ready low the whole pipeline holds.

`include "assert_macros.svh"

module ray_plane_intersect_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  rpi_pkg::in_word_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output rpi_pkg::out_word_t                  out_data,
  input  logic                                cfg_wr_en,
  input  logic [rpi_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rpi_pkg::WORD_W-1:0]          cfg_data
);

  rpi_pkg::plane_t             plane_r;
  logic                        en;
  logic                        d_valid, v_valid;
  rpi_pkg::in_word_t           d_word, v_word;
  logic [rpi_pkg::SN_W-1:0]    sn;
  logic [rpi_pkg::AD_W-1:0]    ad;
  logic                        neg, zero;
  logic [rpi_pkg::Q_W-1:0]     quot;
  rpi_pkg::div_flags_t         flags;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r.normal_x <= '0;
      plane_r.normal_y <= '0;
      plane_r.normal_z <= rpi_pkg::NORMAL_Z_RESET;
      plane_r.center_x <= '0;
      plane_r.center_y <= '0;
      plane_r.center_z <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        rpi_pkg::CFG_NORMAL_X: plane_r.normal_x <= cfg_data;
        rpi_pkg::CFG_NORMAL_Y: plane_r.normal_y <= cfg_data;
        rpi_pkg::CFG_NORMAL_Z: plane_r.normal_z <= cfg_data;
        rpi_pkg::CFG_CENTER_X: plane_r.center_x <= cfg_data;
        rpi_pkg::CFG_CENTER_Y: plane_r.center_y <= cfg_data;
        rpi_pkg::CFG_CENTER_Z: plane_r.center_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // The pipeline advances whenever the output word is free or being taken.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  rpi_dot u_dot (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_word   (in_data),
    .plane     (plane_r),
    .out_valid (d_valid),
    .out_word  (d_word),
    .sn        (sn),
    .ad        (ad),
    .neg       (neg),
    .zero      (zero)
  );

  rpi_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (d_valid),
    .in_word   (d_word),
    .sn        (sn),
    .ad        (ad),
    .neg       (neg),
    .zero      (zero),
    .out_valid (v_valid),
    .out_word  (v_word),
    .quot      (quot),
    .flags     (flags)
  );

  rpi_point u_point (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v_valid),
    .in_word   (v_word),
    .quot      (quot),
    .flags     (flags),
    .out_valid (out_valid),
    .out_word  (out_data)
  );

  // A waiting result word stays put until it is taken.
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int LATENCY = 38;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  rpi_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rpi_pkg::out_word_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [rpi_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rpi_pkg::WORD_W-1:0] cfg_data = '0;

  always #5 clk = ~clk;

  ray_plane_intersect_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  class hit_scoreboard;
    rpi_pkg::plane_t plane;
    rpi_pkg::out_word_t pending[$];
    int errors;
    int hits;
    int checked;

    function new();
      plane = '0;
      plane.normal_z = rpi_pkg::NORMAL_Z_RESET;
      errors = 0;
      hits = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [rpi_pkg::CFG_IDX_W-1:0] idx,
                            logic [rpi_pkg::WORD_W-1:0] val);
      case (idx)
        rpi_pkg::CFG_NORMAL_X: plane.normal_x = val;
        rpi_pkg::CFG_NORMAL_Y: plane.normal_y = val;
        rpi_pkg::CFG_NORMAL_Z: plane.normal_z = val;
        rpi_pkg::CFG_CENTER_X: plane.center_x = val;
        rpi_pkg::CFG_CENTER_Y: plane.center_y = val;
        rpi_pkg::CFG_CENTER_Z: plane.center_z = val;
        default: ;
      endcase
    endfunction

    function logic signed [31:0] clip(logic signed [127:0] v);
      if (v > 128'sd2147483647) return 32'h7fffffff;
      if (v < -128'sd2147483648) return 32'h80000000;
      return v[31:0];
    endfunction

    function logic signed [31:0] coord(logic signed [31:0] o, logic signed [31:0] d,
                                       logic signed [31:0] t);
      logic signed [127:0] p;
      logic [127:0] mag;
      logic signed [127:0] s;
      p = 128'(d) * 128'(t);
      mag = p[127] ? -p : p;
      s = $signed(mag >> 16);
      if (p[127]) s = -s;
      return clip(128'(o) + s);
    endfunction

    // Works out the result of one ray against the current plane.
    function void note_ray(rpi_pkg::in_word_t r);
      logic signed [127:0] num, den, q;
      logic [127:0] an, ad;
      logic signed [31:0] t;
      rpi_pkg::out_word_t e;
      e = '0;
      num = 128'(plane.normal_x) * (128'(plane.center_x) - 128'(r.origin_x))
          + 128'(plane.normal_y) * (128'(plane.center_y) - 128'(r.origin_y))
          + 128'(plane.normal_z) * (128'(plane.center_z) - 128'(r.origin_z));
      den = 128'(plane.normal_x) * 128'(r.dir_x) + 128'(plane.normal_y) * 128'(r.dir_y)
          + 128'(plane.normal_z) * 128'(r.dir_z);
      if (den != 0) begin
        an = num[127] ? -num : num;
        ad = den[127] ? -den : den;
        q = $signed((an << 16) / ad);
        if (num[127] != den[127]) begin
          if (q > 128'sd2147483648) q = 128'sd2147483648;
          t = -q[31:0];
        end else begin
          t = (q > 128'sd2147483647) ? 32'h7fffffff : q[31:0];
        end
        if ((r.backwards && t < 0) || (!r.backwards && t > 0)) begin
          e.hit = 1'b1;
          e.point_x = coord(r.origin_x, r.dir_x, t);
          e.point_y = coord(r.origin_y, r.dir_y, t);
          e.point_z = coord(r.origin_z, r.dir_z, t);
        end
      end
      pending.push_back(e);
    endfunction

    function void check_word(rpi_pkg::out_word_t a);
      rpi_pkg::out_word_t e;
      if (pending.size() == 0) begin
        $error("result word with no ray waiting");
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (a.hit) hits++;
      if (a.hit !== e.hit) begin
        $error("hit: expected %0d, got %0d", e.hit, a.hit); errors++;
      end
      if (a.point_x !== e.point_x) begin
        $error("point_x: expected %0d, got %0d", e.point_x, a.point_x); errors++;
      end
      if (a.point_y !== e.point_y) begin
        $error("point_y: expected %0d, got %0d", e.point_y, a.point_y); errors++;
      end
      if (a.point_z !== e.point_z) begin
        $error("point_z: expected %0d, got %0d", e.point_z, a.point_z); errors++;
      end
    endfunction
  endclass

  hit_scoreboard sb = new();
  int rays_sent = 0;

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_ray(in_data);
    if (rst_n && out_valid && out_ready) sb.check_word(out_data);
  end

  // Receiver: random stalls on out_ready between words, often none at all.
  initial begin
    int gap;
    @(posedge clk iff rst_n);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk iff out_valid);
    end
  end

  task automatic write_plane_reg(logic [rpi_pkg::CFG_IDX_W-1:0] idx,
                                 logic [rpi_pkg::WORD_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_ray(rpi_pkg::in_word_t r, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk iff in_ready);
    rays_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    wait (sb.pending.size() == 0);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 8) << 16;
      3: return $signed(32'($urandom_range(0, 16)) << 16) - (8 << 16);
      4: return $urandom_range(0, 1) ? 32'($urandom_range(0, 3)) : -32'($urandom_range(1, 3));
      default: return $urandom;
    endcase
  endfunction

  function automatic rpi_pkg::in_word_t rand_ray();
    rpi_pkg::in_word_t r;
    r.origin_x = rand_word();
    r.origin_y = rand_word();
    r.origin_z = rand_word();
    r.dir_x = rand_word();
    r.dir_y = rand_word();
    r.dir_z = rand_word();
    r.backwards = $urandom_range(0, 1);
    return r;
  endfunction

  function automatic rpi_pkg::in_word_t mk(int ox, int oy, int oz, int dx, int dy, int dz,
                                           bit b);
    rpi_pkg::in_word_t r;
    r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
    r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
    r.backwards = b;
    return r;
  endfunction

  initial begin
    rpi_pkg::in_word_t dir_q[$];
    bit calm;
    int phase;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rays against the reset plane z = 0.
    dir_q.push_back(mk(0, 0, 5 << 16, 0, 0, -(1 << 16), 0));
    dir_q.push_back(mk(0, 0, 5 << 16, 0, 0, -(1 << 16), 1));
    dir_q.push_back(mk(0, 0, 5 << 16, 0, 0, 1 << 16, 1));
    dir_q.push_back(mk(1 << 16, 2 << 16, 3 << 16, 1 << 16, 0, 0, 0));   // parallel
    dir_q.push_back(mk(1 << 16, 2 << 16, 0, 1 << 16, 1 << 16, 0, 0));   // in the plane
    dir_q.push_back(mk(0, 0, 1, 0, 0, 32'h7fffffff, 0));                // t rounds to zero
    dir_q.push_back(mk(0, 0, 1, 0, 0, 32'h80000000, 1));
    dir_q.push_back(mk(0, 0, 32'h7fffffff, 32'h7fffffff, 32'h80000000, -1, 0));
    dir_q.push_back(mk(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                       32'h80000000, 1, 0));
    dir_q.push_back(mk(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                       32'hffffffff, 32'hffffffff, 1));
    dir_q.push_back(mk(3 << 16, -(3 << 16), 2 << 16, 1 << 16, 1 << 16, -(1 << 16), 0));
    foreach (dir_q[i]) send_ray(dir_q[i], 1'b0);
    drain();

    // Zero normal: every ray misses.
    write_plane_reg(rpi_pkg::CFG_NORMAL_Z, '0);
    for (int i = 0; i < 6; i++) send_ray(rand_ray(), 1'b0);
    drain();

    // Extreme planes, then a string of random planes.
    for (phase = 0; phase < 16; phase++) begin
      if (phase == 0) begin
        write_plane_reg(rpi_pkg::CFG_NORMAL_X, 32'h7fffffff);
        write_plane_reg(rpi_pkg::CFG_NORMAL_Y, 32'h80000000);
        write_plane_reg(rpi_pkg::CFG_NORMAL_Z, 32'h7fffffff);
        write_plane_reg(rpi_pkg::CFG_CENTER_X, 32'h80000000);
        write_plane_reg(rpi_pkg::CFG_CENTER_Y, 32'h7fffffff);
        write_plane_reg(rpi_pkg::CFG_CENTER_Z, 32'h80000000);
      end else if (phase == 1) begin
        write_plane_reg(rpi_pkg::CFG_NORMAL_X, 32'h80000000);
        write_plane_reg(rpi_pkg::CFG_NORMAL_Y, 32'h80000000);
        write_plane_reg(rpi_pkg::CFG_NORMAL_Z, 32'h80000000);
        write_plane_reg(rpi_pkg::CFG_CENTER_X, 32'h7fffffff);
        write_plane_reg(rpi_pkg::CFG_CENTER_Y, 32'h7fffffff);
        write_plane_reg(rpi_pkg::CFG_CENTER_Z, 32'h7fffffff);
        write_plane_reg(3'd7, 32'h12345678);   // beyond the last register, ignored
      end else begin
        write_plane_reg(rpi_pkg::CFG_NORMAL_X, rand_word());
        write_plane_reg(rpi_pkg::CFG_NORMAL_Y, rand_word());
        write_plane_reg(rpi_pkg::CFG_NORMAL_Z, rand_word());
        write_plane_reg(rpi_pkg::CFG_CENTER_X, rand_word());
        write_plane_reg(rpi_pkg::CFG_CENTER_Y, rand_word());
        write_plane_reg(rpi_pkg::CFG_CENTER_Z, rand_word());
      end
      calm = (phase % 4 == 3);
      for (int i = 0; i < 100; i++) send_ray(rand_ray(), calm);
      drain();
    end

    $display("Checked %0d result words from %0d rays, %0d of them hits, over 18 planes.",
             sb.checked, rays_sent, sb.hits);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/rpi_pkg.sv
rtl/rpi_dot.sv
rtl/rpi_div.sv
rtl/rpi_point.sv
rtl/ray_plane_intersect_unit.sv
verif/testbench.sv
